@@ hdl/fvs_pkg.sv @@
package fvs_pkg;

	localparam int VIS_W = 8;
	localparam int PIX_W = 20;
	localparam int NUM_W = 28;
	localparam int QUOT_STEPS = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [VIS_W-1:0] VIS_MAX = 8'd255;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_NUM,
		FS_SAT,
		FS_DIV,
		FS_PUSH
	} fvs_front_state_t;

	typedef struct packed {
		logic             marker;
		logic             slot_ok;
		logic             frame_last;
		logic [VIS_W-1:0] latest;
	} fvs_tag_t;

	localparam int TAG_W = $bits(fvs_tag_t);

	function automatic logic [VIS_W-1:0] smooth_step(input logic [VIS_W-1:0] old,
		input logic [VIS_W-1:0] latest);
		logic [VIS_W+1:0] rise;
		logic [VIS_W:0]   fall;
		rise = {2'b00, old} + {1'b0, old, 1'b0} + {2'b00, latest};
		fall = {1'b0, old} + {1'b0, latest};
		if (latest == '0) begin
			return '0;
		end else if (latest > old) begin
			return rise[VIS_W+1:2];
		end else if (latest < old) begin
			return fall[VIS_W:1];
		end
		return old;
	endfunction

endpackage

@@ hdl/flare_visibility_smoother_unit.sv @@
// Flare visibility smoother: one occlusion result word in, one result word out. The front
// takes a word, forms 255*visible + tested/2 and runs a restoring divider, one quotient bit
// a cycle; a word passes through load, saturation check, 8 divider steps and hand-off (a
// zero tested count or a saturated ratio skips the divider), and the front takes no new
// word until it has handed off the last. The back reads the addressed byte, applies the
// rise/fall smoothing and, when enabled and the slot is in range, writes it back. A
// two-entry queue lets the back drain while the front divides. After reset both tables
// are zeroed by a clearing pass over max(NUM_LIGHTS*FLARES_PER_LIGHT, MARKER_SLOTS)
// *WINDOW_COUNT entries (4096 at the defaults), during which item_stall is high.
module flare_visibility_smoother_unit
	import fvs_pkg::*;
#(
	parameter int WINDOW_COUNT = 4,
	parameter int NUM_LIGHTS = 256,
	parameter int FLARES_PER_LIGHT = 2,
	parameter int MARKER_SLOTS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write_enable,
	input  logic             cfg_write_data,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic             uses_marker_table,
	input  logic [7:0]       light_number,
	input  logic             flare_in_light,
	input  logic [9:0]       marker_slot,
	input  logic [1:0]       window_number,
	input  logic [PIX_W-1:0] tested_pixels,
	input  logic [PIX_W-1:0] visible_pixels,
	input  logic             last_of_frame,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [VIS_W-1:0] smoothed_visibility,
	output logic [VIS_W-1:0] query_visibility,
	output logic             frame_done
);

	localparam int LIGHT_DEPTH = NUM_LIGHTS * FLARES_PER_LIGHT * WINDOW_COUNT;
	localparam int MARKER_DEPTH = MARKER_SLOTS * WINDOW_COUNT;
	localparam int LAW = (LIGHT_DEPTH > 1) ? $clog2(LIGHT_DEPTH) : 1;
	localparam int MAW = (MARKER_DEPTH > 1) ? $clog2(MARKER_DEPTH) : 1;
	localparam int ADDR_W = (LAW > MAW) ? LAW : MAW;
	localparam int WORD_W = ADDR_W + TAG_W;

	logic              enabled_q;
	logic              clearing;
	logic              push_valid;
	logic              push_full;
	fvs_tag_t          push_tag;
	logic [ADDR_W-1:0] push_addr;
	logic              pop_valid;
	logic              pop_ready;
	logic [WORD_W-1:0] pop_word;
	fvs_tag_t          pop_tag;
	logic [ADDR_W-1:0] pop_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
		end else if (cfg_write_enable) begin
			enabled_q <= cfg_write_data;
		end
	end

	fvs_front #(
		.WINDOW_COUNT(WINDOW_COUNT),
		.NUM_LIGHTS(NUM_LIGHTS),
		.FLARES_PER_LIGHT(FLARES_PER_LIGHT),
		.MARKER_SLOTS(MARKER_SLOTS),
		.ADDR_W(ADDR_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.clearing(clearing),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.uses_marker_table(uses_marker_table),
		.light_number(light_number),
		.flare_in_light(flare_in_light),
		.marker_slot(marker_slot),
		.window_number(window_number),
		.tested_pixels(tested_pixels),
		.visible_pixels(visible_pixels),
		.last_of_frame(last_of_frame),
		.push_valid(push_valid),
		.push_full(push_full),
		.push_tag(push_tag),
		.push_addr(push_addr)
	);

	fvs_queue #(
		.WIDTH(WORD_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_full(push_full),
		.push_word({push_addr, push_tag}),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_word(pop_word)
	);

	assign pop_tag = pop_word[TAG_W-1:0];
	assign pop_addr = pop_word[WORD_W-1:TAG_W];

	fvs_back #(
		.LIGHT_DEPTH(LIGHT_DEPTH),
		.MARKER_DEPTH(MARKER_DEPTH),
		.ADDR_W(ADDR_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.enabled(enabled_q),
		.clearing(clearing),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_tag(pop_tag),
		.pop_addr(pop_addr),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.smoothed_visibility(smoothed_visibility),
		.query_visibility(query_visibility),
		.frame_done(frame_done)
	);

endmodule

@@ hdl/fvs_front.sv @@
module fvs_front
	import fvs_pkg::*;
#(
	parameter int WINDOW_COUNT = 4,
	parameter int NUM_LIGHTS = 256,
	parameter int FLARES_PER_LIGHT = 2,
	parameter int MARKER_SLOTS = 1024,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clearing,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              uses_marker_table,
	input  logic [7:0]        light_number,
	input  logic              flare_in_light,
	input  logic [9:0]        marker_slot,
	input  logic [1:0]        window_number,
	input  logic [PIX_W-1:0]  tested_pixels,
	input  logic [PIX_W-1:0]  visible_pixels,
	input  logic              last_of_frame,
	output logic              push_valid,
	input  logic              push_full,
	output fvs_tag_t          push_tag,
	output logic [ADDR_W-1:0] push_addr
);

	fvs_front_state_t state_q, state_d;

	logic              marker_q;
	logic [7:0]        light_q;
	logic              flare_q;
	logic [9:0]        mslot_q;
	logic [1:0]        window_q;
	logic [PIX_W-1:0]  tested_q;
	logic [PIX_W-1:0]  visible_q;
	logic              last_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  div_q;
	logic [VIS_W-1:0]  quot_q;
	logic [2:0]        step_q;
	logic              ok_q;
	logic [ADDR_W-1:0] addr_q;

	logic              accept;
	logic              rem_ge;
	logic [NUM_W-1:0]  num_d;
	logic [31:0]       light_addr;
	logic [31:0]       marker_addr;
	logic              window_ok;
	logic              light_ok;
	logic              mslot_ok;

	assign accept = item_valid && !item_stall;
	assign rem_ge = num_q >= div_q;
	assign num_d = {visible_q, 8'b0} - {8'b0, visible_q} + {9'b0, tested_q[PIX_W-1:1]};
	assign light_addr = ((32'(light_q) * 32'(FLARES_PER_LIGHT) + 32'(flare_q))
		* 32'(WINDOW_COUNT)) + 32'(window_q);
	assign marker_addr = 32'(mslot_q) * 32'(WINDOW_COUNT) + 32'(window_q);
	assign window_ok = 32'(window_q) < 32'(WINDOW_COUNT);
	assign light_ok = (32'(light_q) < 32'(NUM_LIGHTS))
		&& (32'(flare_q) < 32'(FLARES_PER_LIGHT));
	assign mslot_ok = 32'(mslot_q) < 32'(MARKER_SLOTS);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FS_IDLE: begin
				if (accept) begin
					state_d = FS_NUM;
				end
			end
			FS_NUM: state_d = FS_SAT;
			FS_SAT: begin
				if (tested_q == '0 || num_q >= {tested_q, 8'b0}) begin
					state_d = FS_PUSH;
				end else begin
					state_d = FS_DIV;
				end
			end
			FS_DIV: begin
				if (step_q == '0) begin
					state_d = FS_PUSH;
				end
			end
			FS_PUSH: begin
				if (!push_full) begin
					state_d = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end

	always_comb begin
		item_stall = (state_q != FS_IDLE) || clearing;
		push_valid = state_q == FS_PUSH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			FS_IDLE: begin
				if (accept) begin
					marker_q <= uses_marker_table;
					light_q <= light_number;
					flare_q <= flare_in_light;
					mslot_q <= marker_slot;
					window_q <= window_number;
					tested_q <= tested_pixels;
					visible_q <= visible_pixels;
					last_q <= last_of_frame;
				end
			end
			FS_NUM: begin
				num_q <= num_d;
				if (marker_q) begin
					ok_q <= window_ok && mslot_ok;
					addr_q <= marker_addr[ADDR_W-1:0];
				end else begin
					ok_q <= window_ok && light_ok;
					addr_q <= light_addr[ADDR_W-1:0];
				end
			end
			FS_SAT: begin
				div_q <= {1'b0, tested_q, 7'b0};
				step_q <= 3'(QUOT_STEPS - 1);
				if (tested_q == '0) begin
					quot_q <= '0;
				end else begin
					quot_q <= VIS_MAX;
				end
			end
			FS_DIV: begin
				if (rem_ge) begin
					num_q <= num_q - div_q;
				end
				div_q <= div_q >> 1;
				quot_q <= {quot_q[VIS_W-2:0], rem_ge};
				step_q <= step_q - 3'd1;
			end
			FS_PUSH: begin
			end
			default: begin
			end
		endcase
	end

	assign push_tag = '{marker: marker_q, slot_ok: ok_q, frame_last: last_q, latest: quot_q};
	assign push_addr = addr_q;

endmodule

@@ hdl/fvs_queue.sv @@
module fvs_queue
	import fvs_pkg::*;
#(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_full,
	input  logic [WIDTH-1:0] push_word,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_word
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_full = count_q == CNT_W'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_word = slot_q[rd_q];
	assign do_push = push_valid && !push_full;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_word;
		end
	end

endmodule

@@ hdl/fvs_back.sv @@
module fvs_back
	import fvs_pkg::*;
#(
	parameter int LIGHT_DEPTH = 2048,
	parameter int MARKER_DEPTH = 4096,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              enabled,
	output logic              clearing,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  fvs_tag_t          pop_tag,
	input  logic [ADDR_W-1:0] pop_addr,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [VIS_W-1:0]  smoothed_visibility,
	output logic [VIS_W-1:0]  query_visibility,
	output logic              frame_done
);

	localparam int LAW = (LIGHT_DEPTH > 1) ? $clog2(LIGHT_DEPTH) : 1;
	localparam int MAW = (MARKER_DEPTH > 1) ? $clog2(MARKER_DEPTH) : 1;
	localparam int CLR_DEPTH = (LIGHT_DEPTH > MARKER_DEPTH) ? LIGHT_DEPTH : MARKER_DEPTH;
	localparam int CW = $clog2(CLR_DEPTH + 1);

	logic [VIS_W-1:0] light_mem [LIGHT_DEPTH];
	logic [VIS_W-1:0] marker_mem [MARKER_DEPTH];

	logic              clr_busy_q;
	logic [CW-1:0]     clr_cnt_q;
	logic              busy_s1;
	fvs_tag_t          tag_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [VIS_W-1:0]  light_rd_s1;
	logic [VIS_W-1:0]  marker_rd_s1;
	logic              result_valid_q;
	logic [VIS_W-1:0]  smoothed_q;
	logic [VIS_W-1:0]  latest_q;
	logic              done_q;

	logic              do_pop;
	logic [VIS_W-1:0]  old_val;
	logic [VIS_W-1:0]  new_val;
	logic              do_write;

	assign clearing = clr_busy_q;
	assign pop_ready = !clr_busy_q && !busy_s1 && (!result_valid_q || !result_stall);
	assign do_pop = pop_valid && pop_ready;
	assign old_val = tag_s1.marker ? marker_rd_s1 : light_rd_s1;
	assign do_write = busy_s1 && tag_s1.slot_ok && enabled;
	assign new_val = enabled ? smooth_step(old_val, tag_s1.latest) : old_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q <= '0;
			busy_s1 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == CW'(CLR_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			busy_s1 <= do_pop;
			if (busy_s1) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			if (32'(clr_cnt_q) < 32'(LIGHT_DEPTH)) begin
				light_mem[clr_cnt_q[LAW-1:0]] <= '0;
			end
		end else if (do_write && !tag_s1.marker) begin
			light_mem[addr_s1[LAW-1:0]] <= new_val;
		end
		if (do_pop) begin
			light_rd_s1 <= light_mem[pop_addr[LAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			if (32'(clr_cnt_q) < 32'(MARKER_DEPTH)) begin
				marker_mem[clr_cnt_q[MAW-1:0]] <= '0;
			end
		end else if (do_write && tag_s1.marker) begin
			marker_mem[addr_s1[MAW-1:0]] <= new_val;
		end
		if (do_pop) begin
			marker_rd_s1 <= marker_mem[pop_addr[MAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			tag_s1 <= pop_tag;
			addr_s1 <= pop_addr;
		end
		if (busy_s1) begin
			smoothed_q <= tag_s1.slot_ok ? new_val : '0;
			latest_q <= tag_s1.latest;
			done_q <= tag_s1.frame_last;
		end
	end

	assign result_valid = result_valid_q;
	assign smoothed_visibility = smoothed_q;
	assign query_visibility = latest_q;
	assign frame_done = done_q;

endmodule
